>>> src/aspm_pkg.sv
package aspm_pkg;

    localparam int DEVICE_COUNT = 2;
    localparam int CMD_MAX = 4;
    localparam int CMD_CNT_W = 3;

    // Request flag bits per device.
    localparam logic [2:0] F_MUSIC  = 3'b001;
    localparam logic [2:0] F_PROMPT = 3'b010;
    localparam logic [2:0] F_VOICE  = 3'b100;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_STOP   = 2'd1,
        REQ_SWITCH = 2'd2,
        REQ_PSTOP  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_MUSIC   = 2'd0,
        KIND_PROMPT  = 2'd1,
        KIND_VOICE   = 2'd2,
        KIND_INVALID = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        S_NONE   = 2'd0,
        S_MUSIC  = 2'd1,
        S_PROMPT = 2'd2,
        S_VOICE  = 2'd3
    } strm_t;

    typedef enum logic [3:0] {
        CMD_NONE    = 4'd0,
        CMD_SETUP   = 4'd1,
        CMD_M_OPEN  = 4'd2,
        CMD_M_CLOSE = 4'd3,
        CMD_M_RESTART = 4'd4,
        CMD_V_OPEN  = 4'd5,
        CMD_V_CLOSE = 4'd6,
        CMD_P_OPEN  = 4'd7,
        CMD_P_CLOSE = 4'd8,
        CMD_MERGE   = 4'd9,
        CMD_LINK    = 4'd10,
        CMD_QCLEAR  = 4'd11,
        CMD_BOOST   = 4'd12
    } cmd_t;

    typedef enum logic [1:0] {
        ERR_OK       = 2'd0,
        ERR_KIND     = 2'd1,
        ERR_STATE    = 2'd2,
        ERR_DISABLED = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CFG_ENABLE  = 3'd0,
        CFG_PROMPT  = 3'd1,
        CFG_DUAL    = 3'd2,
        CFG_MERGE   = 3'd3,
        CFG_LINK    = 3'd4,
        CFG_TONE    = 3'd5,
        CFG_RATE0   = 3'd6,
        CFG_RATE1   = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic       manager_enable;
        logic       prompt_support;
        logic       dual_device_mode;
        logic       warning_merge_mode;
        logic       link_switch_enable;
        logic [7:0] warning_tone_id;
        logic [7:0] rate_code_dev0;
        logic [7:0] rate_code_dev1;
    } cfg_t;

    // One path command as it travels to the output.
    typedef struct packed {
        cmd_t       kind;
        logic [7:0] param;
        logic       boost;
        logic       dev;
    } cmd_item_t;

    // One classified event: all its commands plus common status.
    typedef struct packed {
        cmd_item_t [CMD_MAX-1:0] cmds;
        logic [CMD_CNT_W-1:0]    count;
        strm_t                   stream;
        err_t                    err;
    } evt_t;

endpackage

>>> src/aspm_front.sv
module aspm_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 evt_push,
    input  logic [1:0]           req_type,
    input  logic [1:0]           stream_kind,
    input  logic                 device_index,
    input  logic [7:0]           prompt_id,
    input  logic                 call_active,
    input  aspm_pkg::cfg_t       cfg,
    output aspm_pkg::evt_t       evt
);
    import aspm_pkg::*;

    logic [2:0] flags_reg [DEVICE_COUNT];
    logic [1:0] owner_reg;
    strm_t      cur_reg;

    logic [2:0] fl [2];
    logic [1:0] own;
    strm_t      cur;
    err_t       err;
    cmd_item_t [CMD_MAX-1:0] q;
    logic [CMD_CNT_W-1:0] n;
    logic       d;
    logic       oth;

    function automatic logic any_f(input logic [2:0] a, input logic [2:0] b,
                                   input logic [2:0] f);
        any_f = ((a & f) != 3'd0) || ((b & f) != 3'd0);
    endfunction

    function automatic logic first_f(input logic [2:0] a, input logic [2:0] f);
        first_f = ((a & f) != 3'd0) ? 1'b0 : 1'b1;
    endfunction

    // Whole event is resolved combinationally; it is a short chain of decisions.
    always_comb
    begin
        logic ok;
        logic mb;
        logic lo;
        fl[0] = flags_reg[0];
        fl[1] = flags_reg[1];
        own = owner_reg;
        cur = cur_reg;
        err = ERR_OK;
        q = '0;
        n = '0;
        d = device_index;
        oth = ~device_index;
        ok = 1'b1;
        mb = 1'b0;
        lo = 1'b0;
        if (!cfg.manager_enable) begin
            err = ERR_DISABLED;
        end else if ((req_type == REQ_START || req_type == REQ_STOP) &&
                     (stream_kind == KIND_INVALID ||
                      (stream_kind == KIND_PROMPT && !cfg.prompt_support))) begin
            err = ERR_KIND;
        end else begin
            case (req_type)
                REQ_START:
                begin
                    fl[d] = fl[d] | (3'd1 << stream_kind);
                    if (stream_kind == KIND_MUSIC) begin
                        if (own[1]) own = {1'b0, d};
                        if (cfg.prompt_support && any_f(fl[0], fl[1], F_PROMPT)) begin
                        end else if (any_f(fl[0], fl[1], F_VOICE)) begin
                            q[n[1:0]] = '{CMD_BOOST, 8'd0, 1'b1, d}; n = n + 1'b1;
                        end else if (cfg.dual_device_mode && (fl[oth] & F_MUSIC) != 0) begin
                            if (own == {1'b0, oth}) begin
                                q[n[1:0]] = '{CMD_M_RESTART, 8'd0, 1'b1, oth}; n = n + 1'b1;
                            end else if (cur != S_MUSIC) begin
                                err = ERR_STATE;
                            end else begin
                                q[n[1:0]] = '{CMD_M_CLOSE, 8'd0, 1'b0, oth}; n = n + 1'b1;
                            end
                        end else begin
                            q[n[1:0]] = '{CMD_SETUP,
                                          d ? cfg.rate_code_dev1 : cfg.rate_code_dev0,
                                          1'b0, d};
                            n = n + 1'b1;
                            q[n[1:0]] = '{CMD_M_OPEN, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_MUSIC;
                        end
                    end else if (stream_kind == KIND_PROMPT) begin
                        if (any_f(fl[0], fl[1], F_VOICE)) begin
                            if (cur == S_VOICE) begin
                                if (call_active) begin
                                    q[n[1:0]] = '{CMD_MERGE, 8'd0, 1'b0, d}; n = n + 1'b1;
                                    fl[0][1] = 1'b0; fl[1][1] = 1'b0;
                                end else begin
                                    q[n[1:0]] = '{CMD_V_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                                    q[n[1:0]] = '{CMD_P_OPEN, prompt_id, 1'b0, d};
                                    n = n + 1'b1;
                                    cur = S_PROMPT;
                                end
                            end else if (cur == S_PROMPT) begin
                                q[n[1:0]] = '{CMD_P_OPEN, prompt_id, 1'b0, d}; n = n + 1'b1;
                            end else err = ERR_STATE;
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            if (cur == S_MUSIC) begin
                                if (cfg.warning_merge_mode && prompt_id == cfg.warning_tone_id)
                                begin
                                    q[n[1:0]] = '{CMD_MERGE, 8'd0, 1'b0, d}; n = n + 1'b1;
                                    fl[0][1] = 1'b0; fl[1][1] = 1'b0;
                                end else begin
                                    q[n[1:0]] = '{CMD_M_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                                    q[n[1:0]] = '{CMD_P_OPEN, prompt_id, 1'b0, d};
                                    n = n + 1'b1;
                                    cur = S_PROMPT;
                                end
                            end else if (cur == S_PROMPT) begin
                                q[n[1:0]] = '{CMD_P_OPEN, prompt_id, 1'b0, d}; n = n + 1'b1;
                            end else err = ERR_STATE;
                        end else begin
                            q[n[1:0]] = '{CMD_P_OPEN, prompt_id, 1'b0, d}; n = n + 1'b1;
                            cur = S_PROMPT;
                        end
                    end else begin
                        if (cfg.prompt_support && any_f(fl[0], fl[1], F_PROMPT)) begin
                            if (call_active) begin
                                if (cur == S_PROMPT) begin
                                    q[n[1:0]] = '{CMD_QCLEAR, 8'd0, 1'b0, d}; n = n + 1'b1;
                                    q[n[1:0]] = '{CMD_P_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                                end
                                fl[0][1] = 1'b0; fl[1][1] = 1'b0;
                                q[n[1:0]] = '{CMD_V_OPEN, 8'd0, 1'b0, d}; n = n + 1'b1;
                                cur = S_VOICE;
                            end
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            if (cur == S_MUSIC) begin
                                q[n[1:0]] = '{CMD_M_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                            end
                            q[n[1:0]] = '{CMD_V_OPEN, 8'd0, 1'b1, d}; n = n + 1'b1;
                            cur = S_VOICE;
                        end else if (cur != S_VOICE) begin
                            q[n[1:0]] = '{CMD_V_OPEN, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_VOICE;
                        end
                    end
                end
                REQ_STOP:
                begin
                    if (stream_kind == KIND_MUSIC) begin
                        fl[d][0] = 1'b0;
                        if (cur == S_MUSIC && own == {1'b0, d}) begin
                            q[n[1:0]] = '{CMD_M_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_NONE;
                        end
                        own = any_f(fl[0], fl[1], F_MUSIC) ?
                              {1'b0, first_f(fl[0], F_MUSIC)} : 2'd2;
                        if (any_f(fl[0], fl[1], F_VOICE)) begin
                        end else if (cfg.prompt_support && any_f(fl[0], fl[1], F_PROMPT))
                        begin
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            mb = 1'b1;
                            lo = first_f(fl[0], F_MUSIC);
                        end
                    end else if (stream_kind == KIND_PROMPT) begin
                        fl[0][1] = 1'b0; fl[1][1] = 1'b0;
                        if (any_f(fl[0], fl[1], F_VOICE)) begin
                            if (cur == S_PROMPT) begin
                                q[n[1:0]] = '{CMD_V_OPEN, 8'd0, 1'b0, d}; n = n + 1'b1;
                                cur = S_VOICE;
                            end
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            mb = 1'b1;
                            lo = (!own[1] && fl[own[0]][0]) ? own[0] :
                                 first_f(fl[0], F_MUSIC);
                        end else cur = S_NONE;
                    end else begin
                        fl[d][2] = 1'b0;
                        if (cfg.prompt_support && any_f(fl[0], fl[1], F_PROMPT)) begin
                            if (cur != S_PROMPT) err = ERR_STATE;
                        end else if (any_f(fl[0], fl[1], F_VOICE)) begin
                            if (cfg.link_switch_enable) begin
                                q[n[1:0]] = '{CMD_LINK, 8'd0, 1'b0, first_f(fl[0], F_VOICE)};
                                n = n + 1'b1;
                            end
                            cur = S_VOICE;
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            q[n[1:0]] = '{CMD_V_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                            mb = 1'b1;
                            lo = (!own[1] && fl[own[0]][0]) ? own[0] :
                                 first_f(fl[0], F_MUSIC);
                        end else begin
                            q[n[1:0]] = '{CMD_V_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_NONE;
                        end
                    end
                end
                default:
                begin
                    // Switch to voice (only when voice is not open) and prompt stop.
                    if ((req_type == REQ_PSTOP || cur != S_VOICE) &&
                        cfg.prompt_support && any_f(fl[0], fl[1], F_PROMPT)) begin
                        q[n[1:0]] = '{CMD_QCLEAR, 8'd0, 1'b0, d}; n = n + 1'b1;
                        if (cur == S_PROMPT) begin
                            q[n[1:0]] = '{CMD_P_CLOSE, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_NONE;
                        end
                        fl[0][1] = 1'b0; fl[1][1] = 1'b0;
                        if (any_f(fl[0], fl[1], F_VOICE)) begin
                            q[n[1:0]] = '{CMD_V_OPEN, 8'd0, 1'b0, d}; n = n + 1'b1;
                            cur = S_VOICE;
                        end else if (any_f(fl[0], fl[1], F_MUSIC)) begin
                            mb = 1'b1;
                            lo = (!own[1] && fl[own[0]][0]) ? own[0] :
                                 first_f(fl[0], F_MUSIC);
                        end
                    end
                end
            endcase
            if (mb) begin
                q[n[1:0]] = '{CMD_SETUP, lo ? cfg.rate_code_dev1 : cfg.rate_code_dev0,
                              1'b0, lo};
                n = n + 1'b1;
                q[n[1:0]] = '{CMD_M_OPEN, 8'd0, 1'b0, lo}; n = n + 1'b1;
                cur = S_MUSIC;
            end
        end
        if (n == '0) begin
            q[0] = '{CMD_NONE, 8'd0, 1'b0, d};
            n = 3'd1;
        end
        ok = (err == ERR_OK || err == ERR_STATE);
        evt.cmds = q;
        evt.count = n;
        evt.stream = ok ? cur : cur_reg;
        evt.err = err;
    end

    // Stream state updates on each accepted event that is not rejected.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            flags_reg[0] <= '0;
            flags_reg[1] <= '0;
            owner_reg <= 2'd2;
            cur_reg <= S_NONE;
        end else if (evt_push && (err == ERR_OK || err == ERR_STATE)) begin
            flags_reg[0] <= fl[0];
            flags_reg[1] <= fl[1];
            owner_reg <= own;
            cur_reg <= cur;
        end
    end

endmodule

>>> src/aspm_queue.sv
module aspm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  aspm_pkg::evt_t wr_data,
    output logic           full,
    input  logic           rd_en,
    output aspm_pkg::evt_t rd_data,
    output logic           rd_valid
);
    import aspm_pkg::*;

    evt_t       mem_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;

    assign full = cnt_reg[1];
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem_reg[rp_reg];

    // Two-entry event queue between classifier and command sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr_en) wp_reg <= ~wp_reg;
            if (rd_en) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) mem_reg[wp_reg] <= wr_data;
    end

endmodule

>>> src/aspm_back.sv
module aspm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  aspm_pkg::evt_t evt,
    input  logic           evt_valid,
    output logic           evt_take,
    output logic           empty,
    input  logic           pop,
    output logic [3:0]     cmd_kind,
    output logic [7:0]     cmd_param,
    output logic           clock_boost,
    output logic           cmd_device,
    output logic [1:0]     open_stream,
    output logic [1:0]     error_code,
    output logic           last
);
    import aspm_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    cmd_item_t  cur;
    logic       is_last;

    assign cur = evt.cmds[idx_reg];
    assign is_last = ({1'b0, idx_reg} + 3'd1) == evt.count;
    assign empty = !evt_valid;
    assign evt_take = evt_valid && pop && is_last;

    assign cmd_kind = cur.kind;
    assign cmd_param = cur.param;
    assign clock_boost = cur.boost;
    assign cmd_device = cur.dev;
    assign open_stream = evt.stream;
    assign error_code = evt.err;
    assign last = is_last;

    // Step through the event's commands one per pop.
    always_comb
    begin
        idx_next = idx_reg;
        if (evt_valid && pop) idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) idx_reg <= 2'd0;
        else idx_reg <= idx_next;
    end

endmodule

>>> src/audio_stream_priority_manager.sv
// Channel | Direction | Handshake     | Payload
// events  | in        | push / full   | req_type stream_kind device_index prompt_id call_active
// results | out       | pop / empty   | cmd_kind cmd_param clock_boost cmd_device open_stream
//         |           |               | error_code last
// config  | in        | cfg_we        | cfg_index cfg_data
// An event is classified in the cycle it is accepted and held in a two-entry queue.
// One command item leaves per pop; an event yields one to four items on the output.
// Events are taken back to back while the queue has room.
// Reset clears request flags, owner, open stream, queue and registers to defaults.
module audio_stream_priority_manager (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] req_type,
    input  logic [1:0] stream_kind,
    input  logic       device_index,
    input  logic [7:0] prompt_id,
    input  logic       call_active,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] cmd_kind,
    output logic [7:0] cmd_param,
    output logic       clock_boost,
    output logic       cmd_device,
    output logic [1:0] open_stream,
    output logic [1:0] error_code,
    output logic       last,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import aspm_pkg::*;

    cfg_t cfg_reg;
    evt_t evt_in;
    evt_t evt_out;
    logic acc;
    logic evt_valid;
    logic evt_take;

    assign acc = push && !full;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 8'd0, 8'd0, 8'd0};
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ENABLE: cfg_reg.manager_enable <= cfg_data[0];
                CFG_PROMPT: cfg_reg.prompt_support <= cfg_data[0];
                CFG_DUAL:   cfg_reg.dual_device_mode <= cfg_data[0];
                CFG_MERGE:  cfg_reg.warning_merge_mode <= cfg_data[0];
                CFG_LINK:   cfg_reg.link_switch_enable <= cfg_data[0];
                CFG_TONE:   cfg_reg.warning_tone_id <= cfg_data;
                CFG_RATE0:  cfg_reg.rate_code_dev0 <= cfg_data;
                CFG_RATE1:  cfg_reg.rate_code_dev1 <= cfg_data;
                default: ;
            endcase
        end
    end

    aspm_front u_front (
        .clk(clk), .rst_n(rst_n), .evt_push(acc), .req_type(req_type),
        .stream_kind(stream_kind), .device_index(device_index), .prompt_id(prompt_id),
        .call_active(call_active), .cfg(cfg_reg), .evt(evt_in)
    );

    aspm_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_en(acc), .wr_data(evt_in), .full(full),
        .rd_en(evt_take), .rd_data(evt_out), .rd_valid(evt_valid)
    );

    aspm_back u_back (
        .clk(clk), .rst_n(rst_n), .evt(evt_out), .evt_valid(evt_valid),
        .evt_take(evt_take), .empty(empty), .pop(pop), .cmd_kind(cmd_kind),
        .cmd_param(cmd_param), .clock_boost(clock_boost), .cmd_device(cmd_device),
        .open_stream(open_stream), .error_code(error_code), .last(last)
    );

    // A none item is always the only item of its event.
    a_none_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && cmd_kind == CMD_NONE) |-> last)
        else $error("none item not last");

    // Rejected events carry no command.
    a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (error_code == ERR_KIND || error_code == ERR_DISABLED))
        |-> cmd_kind == CMD_NONE)
        else $error("rejected event emitted a command");

    // A queue that was full and not drained stays full.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !(pop && last && !empty)) |=> full)
        else $error("queue lost an event");

endmodule

>>> dv/audio_stream_priority_manager_tb.sv
`timescale 1ns / 1ps

module audio_stream_priority_manager_tb;
    import aspm_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [1:0] req_type;
    logic [1:0] stream_kind;
    logic       device_index;
    logic [7:0] prompt_id;
    logic       call_active;
    logic       empty;
    logic       pop;
    logic [3:0] cmd_kind;
    logic [7:0] cmd_param;
    logic       clock_boost;
    logic       cmd_device;
    logic [1:0] open_stream;
    logic [1:0] error_code;
    logic       last;
    logic       cfg_we;
    logic [2:0] cfg_index;
    logic [7:0] cfg_data;

    audio_stream_priority_manager dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .req_type(req_type), .stream_kind(stream_kind), .device_index(device_index),
        .prompt_id(prompt_id), .call_active(call_active), .empty(empty), .pop(pop),
        .cmd_kind(cmd_kind), .cmd_param(cmd_param), .clock_boost(clock_boost),
        .cmd_device(cmd_device), .open_stream(open_stream), .error_code(error_code),
        .last(last), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // One expected path command with the status fields of its event.
    typedef struct packed {
        cmd_t       kind;
        logic [7:0] param;
        logic       boost;
        logic       dev;
        strm_t      stream;
        err_t       err;
        logic       last;
    } path_cmd_t;

    // One event in the directed table; chk set means the result is typed in.
    typedef struct {
        req_t       req;
        kind_t      kind;
        logic       dev;
        logic [7:0] pid;
        logic       call;
        logic       chk;
        path_cmd_t  exp_cmd;
    } event_row_t;

    path_cmd_t  pending_cmds[$];
    path_cmd_t  typed_cmds[$];
    cfg_t       regs;
    logic [2:0] dev_flags[2];
    logic [1:0] owner;
    strm_t      path_stream;
    path_cmd_t  burst[$];
    int         errors;
    int         quiet_cycles;
    int         push_idle_pct;
    int         pop_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Path arbitration state held by the testbench.
    function automatic void add_cmd(cmd_t k, logic [7:0] p, logic b, logic d);
        path_cmd_t c;
        if (burst.size() >= CMD_MAX)
            return;
        c = '0;
        c.kind = k;
        c.param = p;
        c.boost = b;
        c.dev = d;
        burst.push_back(c);
    endfunction

    function automatic bit any_flag(logic [2:0] f);
        return ((dev_flags[0] | dev_flags[1]) & f) != 0;
    endfunction

    function automatic logic first_flag(logic [2:0] f);
        return (dev_flags[0] & f) ? 1'b0 : ((dev_flags[1] & f) ? 1'b1 : 1'b0);
    endfunction

    function automatic void drop_prompts();
        dev_flags[0] &= ~F_PROMPT;
        dev_flags[1] &= ~F_PROMPT;
    endfunction

    function automatic logic [7:0] rate_for(logic d);
        return d ? regs.rate_code_dev1 : regs.rate_code_dev0;
    endfunction

    function automatic logic music_dev();
        if (owner < DEVICE_COUNT && (dev_flags[owner[0]] & F_MUSIC))
            return owner[0];
        return first_flag(F_MUSIC);
    endfunction

    function automatic void open_music(logic d);
        add_cmd(CMD_SETUP, rate_for(d), 1'b0, d);
        add_cmd(CMD_M_OPEN, 8'd0, 1'b0, d);
        path_stream = S_MUSIC;
    endfunction

    function automatic bit prompts_live();
        return regs.prompt_support && any_flag(F_PROMPT);
    endfunction

    function automatic void end_prompt(logic d);
        if (!prompts_live())
            return;
        add_cmd(CMD_QCLEAR, 8'd0, 1'b0, d);
        if (path_stream == S_PROMPT)
        begin
            add_cmd(CMD_P_CLOSE, 8'd0, 1'b0, d);
            path_stream = S_NONE;
        end
        drop_prompts();
        if (any_flag(F_VOICE))
        begin
            add_cmd(CMD_V_OPEN, 8'd0, 1'b0, d);
            path_stream = S_VOICE;
        end
        else if (any_flag(F_MUSIC))
            open_music(music_dev());
    endfunction

    function automatic err_t start_stream(kind_t k, logic d, logic [7:0] pid, logic call);
        logic other;
        other = ~d;
        dev_flags[d] |= 3'(1 << k);
        if (k == KIND_MUSIC)
        begin
            if (owner >= DEVICE_COUNT)
                owner = {1'b0, d};
            if (prompts_live())
                return ERR_OK;
            if (any_flag(F_VOICE))
            begin
                add_cmd(CMD_BOOST, 8'd0, 1'b1, d);
                return ERR_OK;
            end
            if (regs.dual_device_mode && (dev_flags[other] & F_MUSIC))
            begin
                if (owner == {1'b0, other})
                begin
                    add_cmd(CMD_M_RESTART, 8'd0, 1'b1, other);
                    return ERR_OK;
                end
                if (path_stream != S_MUSIC)
                    return ERR_STATE;
                add_cmd(CMD_M_CLOSE, 8'd0, 1'b0, other);
                return ERR_OK;
            end
            open_music(d);
        end
        else if (k == KIND_PROMPT)
        begin
            if (any_flag(F_VOICE))
            begin
                if (path_stream == S_VOICE)
                begin
                    if (call)
                    begin
                        add_cmd(CMD_MERGE, 8'd0, 1'b0, d);
                        drop_prompts();
                    end
                    else
                    begin
                        add_cmd(CMD_V_CLOSE, 8'd0, 1'b0, d);
                        add_cmd(CMD_P_OPEN, pid, 1'b0, d);
                        path_stream = S_PROMPT;
                    end
                end
                else if (path_stream == S_PROMPT)
                    add_cmd(CMD_P_OPEN, pid, 1'b0, d);
                else
                    return ERR_STATE;
            end
            else if (any_flag(F_MUSIC))
            begin
                if (path_stream == S_MUSIC)
                begin
                    if (regs.warning_merge_mode && pid == regs.warning_tone_id)
                    begin
                        add_cmd(CMD_MERGE, 8'd0, 1'b0, d);
                        drop_prompts();
                    end
                    else
                    begin
                        add_cmd(CMD_M_CLOSE, 8'd0, 1'b0, d);
                        add_cmd(CMD_P_OPEN, pid, 1'b0, d);
                        path_stream = S_PROMPT;
                    end
                end
                else if (path_stream == S_PROMPT)
                    add_cmd(CMD_P_OPEN, pid, 1'b0, d);
                else
                    return ERR_STATE;
            end
            else
            begin
                add_cmd(CMD_P_OPEN, pid, 1'b0, d);
                path_stream = S_PROMPT;
            end
        end
        else
        begin
            if (prompts_live())
            begin
                if (call)
                begin
                    if (path_stream == S_PROMPT)
                    begin
                        add_cmd(CMD_QCLEAR, 8'd0, 1'b0, d);
                        add_cmd(CMD_P_CLOSE, 8'd0, 1'b0, d);
                    end
                    drop_prompts();
                    add_cmd(CMD_V_OPEN, 8'd0, 1'b0, d);
                    path_stream = S_VOICE;
                end
            end
            else if (any_flag(F_MUSIC))
            begin
                if (path_stream == S_MUSIC)
                    add_cmd(CMD_M_CLOSE, 8'd0, 1'b0, d);
                add_cmd(CMD_V_OPEN, 8'd0, 1'b1, d);
                path_stream = S_VOICE;
            end
            else if (path_stream != S_VOICE)
            begin
                add_cmd(CMD_V_OPEN, 8'd0, 1'b0, d);
                path_stream = S_VOICE;
            end
        end
        return ERR_OK;
    endfunction

    function automatic err_t stop_stream(kind_t k, logic d);
        if (k == KIND_MUSIC)
        begin
            dev_flags[d] &= ~F_MUSIC;
            if (path_stream == S_MUSIC && owner == {1'b0, d})
            begin
                add_cmd(CMD_M_CLOSE, 8'd0, 1'b0, d);
                path_stream = S_NONE;
            end
            owner = any_flag(F_MUSIC) ? {1'b0, first_flag(F_MUSIC)} : 2'd2;
            if (any_flag(F_VOICE) || prompts_live())
                return ERR_OK;
            if (any_flag(F_MUSIC))
                open_music(first_flag(F_MUSIC));
        end
        else if (k == KIND_PROMPT)
        begin
            drop_prompts();
            if (any_flag(F_VOICE))
            begin
                if (path_stream == S_PROMPT)
                begin
                    add_cmd(CMD_V_OPEN, 8'd0, 1'b0, d);
                    path_stream = S_VOICE;
                end
            end
            else if (any_flag(F_MUSIC))
                open_music(music_dev());
            else
                path_stream = S_NONE;
        end
        else
        begin
            dev_flags[d] &= ~F_VOICE;
            if (prompts_live())
            begin
                if (path_stream != S_PROMPT)
                    return ERR_STATE;
            end
            else if (any_flag(F_VOICE))
            begin
                if (regs.link_switch_enable)
                    add_cmd(CMD_LINK, 8'd0, 1'b0, first_flag(F_VOICE));
                path_stream = S_VOICE;
            end
            else
            begin
                add_cmd(CMD_V_CLOSE, 8'd0, 1'b0, d);
                if (any_flag(F_MUSIC))
                    open_music(music_dev());
                else
                    path_stream = S_NONE;
            end
        end
        return ERR_OK;
    endfunction

    // Works out the command run of one event and queues it as expected.
    function automatic void predict_event(req_t r, kind_t k, logic d, logic [7:0] pid,
                                          logic call);
        err_t e;
        path_cmd_t c;
        e = ERR_OK;
        burst.delete();
        if (!regs.manager_enable)
            e = ERR_DISABLED;
        else if (r <= REQ_STOP && (k == KIND_INVALID || (k == KIND_PROMPT
                 && !regs.prompt_support)))
            e = ERR_KIND;
        else if (r == REQ_START)
            e = start_stream(k, d, pid, call);
        else if (r == REQ_STOP)
            e = stop_stream(k, d);
        else if (r == REQ_SWITCH)
        begin
            if (path_stream != S_VOICE)
                end_prompt(d);
        end
        else
            end_prompt(d);
        if (burst.size() == 0)
            add_cmd(CMD_NONE, 8'd0, 1'b0, d);
        foreach (burst[i])
        begin
            c = burst[i];
            c.stream = path_stream;
            c.err = e;
            c.last = (i == burst.size() - 1);
            pending_cmds.push_back(c);
        end
    endfunction

    // Writes one register, then waits with the enable low so that writes stay apart.
    task automatic write_reg(cfg_idx_t idx, logic [7:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE: regs.manager_enable = val[0];
            CFG_PROMPT: regs.prompt_support = val[0];
            CFG_DUAL:   regs.dual_device_mode = val[0];
            CFG_MERGE:  regs.warning_merge_mode = val[0];
            CFG_LINK:   regs.link_switch_enable = val[0];
            CFG_TONE:   regs.warning_tone_id = val;
            CFG_RATE0:  regs.rate_code_dev0 = val;
            default:    regs.rate_code_dev1 = val;
        endcase
        @(posedge clk);
    endtask

    // Waits until the block has returned everything, with push held low.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Presents one event and holds it until it is accepted.
    task automatic send_event(req_t r, kind_t k, logic d, logic [7:0] pid, logic call);
        while ($urandom_range(99) < push_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        req_type <= r;
        stream_kind <= k;
        device_index <= d;
        prompt_id <= pid;
        call_active <= call;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_event(r, k, d, pid, call);
    endtask

    task automatic send_random();
        kind_t k;
        logic [7:0] pid;
        k = kind_t'($urandom_range(99) < 5 ? 3 : $urandom_range(2));
        pid = ($urandom_range(3) == 0) ? regs.warning_tone_id : 8'($urandom);
        send_event(req_t'($urandom_range(3)), k, 1'($urandom), pid, 1'($urandom));
    endtask

    // Result side: random stalls and the compare against the oldest expectation.
    always @(posedge clk)
    begin
        path_cmd_t e;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_cmds.size() == 0)
                begin
                    $display("%0t: unexpected command kind=%0d", $time, cmd_kind);
                    errors++;
                end
                else
                begin
                    e = pending_cmds.pop_front();
                    if (typed_cmds.size() != 0 && e.last)
                    begin
                        if (typed_cmds[0] != e)
                        begin
                            $display("%0t: table row expected %h predicted %h", $time,
                                     typed_cmds[0], e);
                            errors++;
                        end
                        void'(typed_cmds.pop_front());
                    end
                    if ({cmd_kind, cmd_param, clock_boost, cmd_device, open_stream,
                         error_code, last} != e)
                    begin
                        $display("%0t: expected kind=%0d param=%0d boost=%0d dev=%0d",
                                 $time, e.kind, e.param, e.boost, e.dev);
                        $display("  stream=%0d err=%0d last=%0d; actual %0d %0d %0d %0d %0d %0d %0d",
                                 e.stream, e.err, e.last, cmd_kind, cmd_param,
                                 clock_boost, cmd_device, open_stream, error_code, last);
                        errors++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    event_row_t rows[$];

    function automatic path_cmd_t none_cmd(err_t e, logic d);
        path_cmd_t c;
        c = '0;
        c.kind = CMD_NONE;
        c.dev = d;
        c.err = e;
        c.last = 1'b1;
        return c;
    endfunction

    function automatic void add_row(req_t r, kind_t k, logic d, logic [7:0] pid,
                                    logic call, logic chk, path_cmd_t c);
        event_row_t row;
        row.req = r;
        row.kind = k;
        row.dev = d;
        row.pid = pid;
        row.call = call;
        row.chk = chk;
        row.exp_cmd = c;
        rows.push_back(row);
    endfunction

    initial
    begin
        errors = 0;
        push = 0; req_type = 0; stream_kind = 0; device_index = 0; prompt_id = 0;
        call_active = 0; pop = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        push_idle_pct = 7;
        pop_idle_pct = 81;
        regs = '0;
        regs.prompt_support = 1'b1;
        regs.dual_device_mode = 1'b1;
        regs.link_switch_enable = 1'b1;
        dev_flags[0] = '0;
        dev_flags[1] = '0;
        owner = 2'd2;
        path_stream = S_NONE;
        rst_n = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed table; the first row meets the disabled block after reset.
        add_row(REQ_START, KIND_MUSIC, 1'b1, 8'hFF, 1'b1, 1'b1, none_cmd(ERR_DISABLED, 1'b1));
        foreach (rows[i])
        begin
            if (rows[i].chk)
                typed_cmds.push_back(rows[i].exp_cmd);
            send_event(rows[i].req, rows[i].kind, rows[i].dev, rows[i].pid, rows[i].call);
        end
        wait_drained();
        rows.delete();
        write_reg(CFG_ENABLE, 8'd1);
        write_reg(CFG_RATE0, 8'hFF);
        write_reg(CFG_RATE1, 8'h5A);
        write_reg(CFG_TONE, 8'hFF);
        write_reg(CFG_MERGE, 8'd1);
        add_row(REQ_START, KIND_INVALID, 1'b0, 8'h00, 1'b0, 1'b1, none_cmd(ERR_KIND, 1'b0));
        add_row(REQ_STOP, KIND_INVALID, 1'b1, 8'h00, 1'b0, 1'b1, none_cmd(ERR_KIND, 1'b1));
        add_row(REQ_START, KIND_MUSIC, 1'b0, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_MUSIC, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_PROMPT, 1'b0, 8'hFF, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_PROMPT, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_PROMPT, 1'b0, 8'hA5, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_VOICE, 1'b1, 8'h00, 1'b1, 1'b0, '0);
        add_row(REQ_START, KIND_PROMPT, 1'b0, 8'h3C, 1'b1, 1'b0, '0);
        add_row(REQ_START, KIND_PROMPT, 1'b0, 8'h3C, 1'b0, 1'b0, '0);
        add_row(REQ_STOP, KIND_VOICE, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_PSTOP, KIND_INVALID, 1'b0, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_VOICE, 1'b0, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_START, KIND_VOICE, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_STOP, KIND_VOICE, 1'b0, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_SWITCH, KIND_INVALID, 1'b1, 8'h00, 1'b1, 1'b0, '0);
        add_row(REQ_STOP, KIND_VOICE, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_STOP, KIND_MUSIC, 1'b0, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_STOP, KIND_PROMPT, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        add_row(REQ_STOP, KIND_MUSIC, 1'b1, 8'h00, 1'b0, 1'b0, '0);
        foreach (rows[i])
        begin
            if (rows[i].chk)
                typed_cmds.push_back(rows[i].exp_cmd);
            send_event(rows[i].req, rows[i].kind, rows[i].dev, rows[i].pid, rows[i].call);
        end
        wait_drained();

        // Prompt handling, dual-device mode and link switching off; a prompt start is then rejected.
        write_reg(CFG_PROMPT, 8'd0);
        write_reg(CFG_DUAL, 8'd0);
        write_reg(CFG_LINK, 8'd0);
        typed_cmds.push_back(none_cmd(ERR_KIND, 1'b0));
        send_event(REQ_START, KIND_PROMPT, 1'b0, 8'h11, 1'b0);
        repeat (10) send_random();
        wait_drained();

        // Random phases over several register settings and idling patterns.
        for (int ph = 0; ph < 3; ph++)
        begin
            push_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 81 : 0;
            pop_idle_pct = (ph == 0) ? 81 : (ph == 1) ? 7 : 0;
            write_reg(CFG_PROMPT, 8'(ph != 2 || $urandom_range(1)));
            write_reg(CFG_DUAL, 8'(ph != 1));
            write_reg(CFG_MERGE, 8'(ph == 2));
            write_reg(CFG_LINK, 8'(ph != 0));
            write_reg(CFG_TONE, (ph == 1) ? 8'h00 : 8'($urandom));
            write_reg(CFG_RATE0, 8'($urandom));
            write_reg(CFG_RATE1, (ph == 2) ? 8'h00 : 8'($urandom));
            repeat (20) send_random();
            // Hold off until the block is fully drained mid-phase.
            push <= 1'b0;
            while (pending_cmds.size() != 0)
                @(posedge clk);
            repeat ($urandom_range(1, 5)) @(posedge clk);
            repeat (5) send_random();
            wait_drained();
        end
        write_reg(CFG_ENABLE, 8'd0);
        repeat (3) send_random();
        wait_drained();

        if (errors == 0 && typed_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Ends the run when nothing moves for too long.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet_cycles > 3000)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
